// ----- hdl/obb_pkg.sv -----
// shared types, constants and codes for the orthonormal basis builder
package obb_pkg;

  // fixed point format and field widths
  localparam int FRAC_BITS = 14;
  localparam int IN_BITS   = 16;
  localparam int OUT_BITS  = 16;
  localparam int RAW_BITS  = 32;
  localparam int MAG_BITS  = RAW_BITS - 1;
  localparam int EPS_BITS  = 15;
  localparam int EPS2_BITS = 2 * EPS_BITS;
  localparam int DATA_BITS = 9 * IN_BITS;
  localparam int OP_BITS   = 4;

  localparam logic [EPS_BITS-1:0] EPS_RESET = 15'd164;

  // normaliser pipeline shape
  localparam int SHIFT_STEPS = 5;
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = FRAC_BITS + 1;
  localparam int NUM_BITS    = MAG_BITS + FRAC_BITS + 1;
  localparam int NORM_LAT    = 1 + SHIFT_STEPS + 2 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  // front to back queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // register map
  localparam int PADDR_BITS = 3;
  localparam logic [PADDR_BITS-1:0] ADDR_EPS = 3'd0;

  // operation codes
  localparam logic [OP_BITS-1:0] OP_FROM_U = 4'd0;
  localparam logic [OP_BITS-1:0] OP_FROM_V = 4'd1;
  localparam logic [OP_BITS-1:0] OP_FROM_W = 4'd2;
  localparam logic [OP_BITS-1:0] OP_UV     = 4'd3;
  localparam logic [OP_BITS-1:0] OP_UW     = 4'd4;
  localparam logic [OP_BITS-1:0] OP_VU     = 4'd5;
  localparam logic [OP_BITS-1:0] OP_VW     = 4'd6;
  localparam logic [OP_BITS-1:0] OP_WU     = 4'd7;
  localparam logic [OP_BITS-1:0] OP_WV     = 4'd8;

  // axis slots
  localparam logic [1:0] SLOT_U = 2'd0;
  localparam logic [1:0] SLOT_V = 2'd1;
  localparam logic [1:0] SLOT_W = 2'd2;

  typedef logic [2:0][IN_BITS-1:0]  vec_t;
  typedef logic [2:0][RAW_BITS-1:0] raw_t;

  // how the back end places and combines the axes
  typedef struct packed {
    logic       ok;
    logic       pair;
    logic [1:0] n_slot;
    logic [1:0] s_slot;
    logic       swap;
  } ctl_t;

  typedef struct packed {
    ctl_t ctl;
    vec_t a;
    raw_t t;
  } entry_t;

endpackage

// ----- hdl/obb_fifo.sv -----
// short queue between the front and back ends
module obb_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  obb_pkg::entry_t wdata,
  input  logic            pop,
  output obb_pkg::entry_t rdata,
  output logic            full,
  output logic            empty
);
  import obb_pkg::*;

  entry_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  assign rdata = slots[rd_ptr];
  assign full  = (count == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty = (count == '0);

endmodule

// ----- hdl/obb_front.sv -----
// front end: accepts words, decodes the mode and forms the raw cross product
module obb_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [obb_pkg::DATA_BITS-1:0] s_tdata,
  input  logic [obb_pkg::OP_BITS-1:0]   s_tuser,
  input  logic                          fifo_full,
  output logic                          push,
  output obb_pkg::entry_t               push_data
);
  import obb_pkg::*;

  logic                       en;
  logic                       take;
  vec_t                       gu, gv, gw;
  vec_t                       a_sel, p_sel, q_sel;
  ctl_t                       ctl_in;
  logic                       f_valid;
  ctl_t                       f_ctl;
  vec_t                       f_a;
  logic signed [RAW_BITS-1:0] f_p [6];

  assign gu = s_tdata[3*IN_BITS-1:0];
  assign gv = s_tdata[6*IN_BITS-1:3*IN_BITS];
  assign gw = s_tdata[9*IN_BITS-1:6*IN_BITS];

  assign en       = !fifo_full;
  assign s_tready = en;
  assign take     = s_tvalid && s_tready;

  // mode decode: vector to normalise, pair to cross, placement
  always_comb begin
    ctl_in = '{ok: 1'b1, pair: 1'b0, n_slot: SLOT_U, s_slot: SLOT_V, swap: 1'b0};
    a_sel  = gu;
    p_sel  = gu;
    q_sel  = gv;
    case (s_tuser)
      OP_FROM_U: begin
        ctl_in.n_slot = SLOT_U; ctl_in.s_slot = SLOT_V;
      end
      OP_FROM_V: begin
        a_sel = gv; ctl_in.n_slot = SLOT_V; ctl_in.s_slot = SLOT_U; ctl_in.swap = 1'b1;
      end
      OP_FROM_W: begin
        a_sel = gw; ctl_in.n_slot = SLOT_W; ctl_in.s_slot = SLOT_U;
      end
      OP_UV: begin
        ctl_in.pair = 1'b1; ctl_in.n_slot = SLOT_U; ctl_in.s_slot = SLOT_W;
        ctl_in.swap = 1'b1;
      end
      OP_UW: begin
        ctl_in.pair = 1'b1; p_sel = gw; q_sel = gu;
        ctl_in.n_slot = SLOT_U; ctl_in.s_slot = SLOT_V;
      end
      OP_VU: begin
        ctl_in.pair = 1'b1; a_sel = gv;
        ctl_in.n_slot = SLOT_V; ctl_in.s_slot = SLOT_W;
      end
      OP_VW: begin
        ctl_in.pair = 1'b1; a_sel = gv; p_sel = gv; q_sel = gw;
        ctl_in.n_slot = SLOT_V; ctl_in.s_slot = SLOT_U; ctl_in.swap = 1'b1;
      end
      OP_WU: begin
        ctl_in.pair = 1'b1; a_sel = gw; p_sel = gw; q_sel = gu;
        ctl_in.n_slot = SLOT_W; ctl_in.s_slot = SLOT_V; ctl_in.swap = 1'b1;
      end
      OP_WV: begin
        ctl_in.pair = 1'b1; a_sel = gw; p_sel = gv; q_sel = gw;
        ctl_in.n_slot = SLOT_W; ctl_in.s_slot = SLOT_U;
      end
      default: begin
        ctl_in.ok = 1'b0;
      end
    endcase
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (en) f_valid <= take;
  end

  // product stage
  always_ff @(posedge clk) begin
    if (en) begin
      f_ctl  <= ctl_in;
      f_a    <= a_sel;
      f_p[0] <= $signed(p_sel[1]) * $signed(q_sel[2]);
      f_p[1] <= $signed(p_sel[2]) * $signed(q_sel[1]);
      f_p[2] <= $signed(p_sel[2]) * $signed(q_sel[0]);
      f_p[3] <= $signed(p_sel[0]) * $signed(q_sel[2]);
      f_p[4] <= $signed(p_sel[0]) * $signed(q_sel[1]);
      f_p[5] <= $signed(p_sel[1]) * $signed(q_sel[0]);
    end
  end

  // differences go straight into the queue
  assign push            = f_valid && en;
  assign push_data.ctl   = f_ctl;
  assign push_data.a     = f_a;
  assign push_data.t[0]  = f_p[0] - f_p[1];
  assign push_data.t[1]  = f_p[2] - f_p[3];
  assign push_data.t[2]  = f_p[4] - f_p[5];

endmodule

// ----- hdl/obb_norm.sv -----
// pipelined vector normaliser: pre-shift, square root and three dividers
module obb_norm (
  input  logic          clk,
  input  logic          en,
  input  obb_pkg::raw_t vec_in,
  output obb_pkg::vec_t q_out,
  output logic          zero_out
);
  import obb_pkg::*;

  logic [MAG_BITS-1:0]   sh_mg [SHIFT_STEPS+1][3];
  logic [MAG_BITS-1:0]   sh_m  [SHIFT_STEPS+1];
  logic [2:0]            sg_d  [NORM_LAT-1];
  logic                  zr_d  [NORM_LAT-1];
  logic [MAG_BITS-1:0]   mgd   [SQRT_STEPS+2][3];
  logic [2*MAG_BITS-1:0] sq    [3];
  logic [63:0]           sr_s  [SQRT_STEPS+1];
  logic [63:0]           sr_r  [SQRT_STEPS+1];
  logic [31:0]           dv_len [DIV_STEPS+1];
  logic [31:0]           dv_rem [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0]  dv_nb  [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0]  dv_q   [DIV_STEPS+1][3];
  logic [RAW_BITS-1:0]   mag_in [3];
  logic [MAG_BITS-1:0]   max_in;

  // magnitudes and largest component
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec_in[i][RAW_BITS-1] ? RAW_BITS'(-$signed(vec_in[i])) : vec_in[i];
    end
    max_in = mag_in[0][MAG_BITS-1:0];
    if (mag_in[1][MAG_BITS-1:0] > max_in) max_in = mag_in[1][MAG_BITS-1:0];
    if (mag_in[2][MAG_BITS-1:0] > max_in) max_in = mag_in[2][MAG_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sh_mg[0][i] <= mag_in[i][MAG_BITS-1:0];
        sg_d[0][i]  <= vec_in[i][RAW_BITS-1];
      end
      sh_m[0] <= max_in;
      zr_d[0] <= (max_in == '0);
    end
  end

  // sign and zero flag ride alongside
  for (genvar k = 1; k < NORM_LAT - 1; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        sg_d[k] <= sg_d[k-1];
        zr_d[k] <= zr_d[k-1];
      end
    end
  end

  // left shift until the top magnitude bit is set
  for (genvar k = 0; k < SHIFT_STEPS; k++) begin : g_shift
    localparam int SH = 16 >> k;
    logic go;
    assign go = (sh_m[k][MAG_BITS-1 -: SH] == '0);
    always_ff @(posedge clk) begin
      if (en) begin
        sh_m[k+1] <= go ? (sh_m[k] << SH) : sh_m[k];
        for (int i = 0; i < 3; i++) begin
          sh_mg[k+1][i] <= go ? (sh_mg[k][i] << SH) : sh_mg[k][i];
        end
      end
    end
  end

  // squares, then their sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i]     <= sh_mg[SHIFT_STEPS][i] * sh_mg[SHIFT_STEPS][i];
        mgd[0][i] <= sh_mg[SHIFT_STEPS][i];
        mgd[1][i] <= mgd[0][i];
      end
      sr_s[0] <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      sr_r[0] <= '0;
    end
  end

  // square root, one result bit a stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = sr_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sr_s[j] >= trial) begin
          sr_s[j+1] <= sr_s[j] - trial;
          sr_r[j+1] <= (sr_r[j] >> 1) + BIT;
        end else begin
          sr_s[j+1] <= sr_s[j];
          sr_r[j+1] <= sr_r[j] >> 1;
        end
        for (int i = 0; i < 3; i++) mgd[j+2][i] <= mgd[j+1][i];
      end
    end
  end

  // divider setup: rounded numerator, leading partial remainder
  always_ff @(posedge clk) begin
    logic [NUM_BITS-1:0] num;
    if (en) begin
      dv_len[0] <= sr_r[SQRT_STEPS][31:0];
      for (int i = 0; i < 3; i++) begin
        num = {1'b0, mgd[SQRT_STEPS+1][i], {FRAC_BITS{1'b0}}}
            + NUM_BITS'(sr_r[SQRT_STEPS][31:1]);
        dv_rem[0][i] <= 32'(num[NUM_BITS-1:DIV_STEPS]);
        dv_nb[0][i]  <= num[DIV_STEPS-1:0];
        dv_q[0][i]   <= '0;
      end
    end
  end

  // restoring division, one quotient bit a stage
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    always_ff @(posedge clk) begin
      logic [32:0] rem2;
      logic        ge;
      if (en) begin
        dv_len[s+1] <= dv_len[s];
        for (int i = 0; i < 3; i++) begin
          rem2 = {dv_rem[s][i], dv_nb[s][i][DIV_STEPS-1-s]};
          ge   = (rem2 >= {1'b0, dv_len[s]});
          dv_rem[s+1][i] <= ge ? 32'(rem2 - {1'b0, dv_len[s]}) : rem2[31:0];
          dv_q[s+1][i]   <= {dv_q[s][i][DIV_STEPS-2:0], ge};
          dv_nb[s+1][i]  <= dv_nb[s][i];
        end
      end
    end
  end

  // clamp to one and restore the sign
  always_ff @(posedge clk) begin
    logic [DIV_STEPS-1:0] qc;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qc = dv_q[DIV_STEPS][i];
        if (qc > DIV_STEPS'(1 << FRAC_BITS)) qc = DIV_STEPS'(1 << FRAC_BITS);
        if (zr_d[NORM_LAT-2]) q_out[i] <= '0;
        else if (sg_d[NORM_LAT-2][i]) q_out[i] <= OUT_BITS'(-$signed({1'b0, qc}));
        else q_out[i] <= OUT_BITS'({1'b0, qc});
      end
      zero_out <= zr_d[NORM_LAT-2];
    end
  end

endmodule

// ----- hdl/obb_back.sv -----
// back end: normalises, picks the perpendicular axis, crosses and places axes
module obb_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [obb_pkg::EPS2_BITS-1:0] eps2,
  input  obb_pkg::entry_t               rdata,
  input  logic                          fifo_empty,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [obb_pkg::DATA_BITS-1:0] m_tdata,
  output logic [0:0]                    m_tuser
);
  import obb_pkg::*;

  logic                       adv;
  raw_t                       a_wide;
  vec_t                       nq, mq;
  logic                       nz, mz;
  logic                       cd_valid [NORM_LAT];
  ctl_t                       cd_ctl   [NORM_LAT];
  logic                       p1_valid, p2_valid, c1_valid;
  ctl_t                       p1_ctl, p2_ctl, c1_ctl;
  logic                       p1_deg, p2_deg, c1_deg;
  vec_t                       p1_n, p1_m, p2_n, p2_s, c1_n, c1_s;
  vec_t                       p2_l, p2_r;
  logic [28:0]                p1_s1, p1_s2;
  logic signed [31:0]         sq1, sq2;
  logic signed [RAW_BITS-1:0] c1_p [6];
  vec_t                       perp, sec, crs;
  vec_t                       ax [3];
  logic [1:0]                 c_slot;

  function automatic logic [OUT_BITS-1:0] round_q(input logic signed [32:0] p);
    logic [32:0] mag;
    logic [32:0] r;
    mag = p[32] ? 33'(-p) : p;
    r   = (mag + 33'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (r > 33'(1 << FRAC_BITS)) r = 33'(1 << FRAC_BITS);
    return p[32] ? OUT_BITS'(-$signed(r)) : r[OUT_BITS-1:0];
  endfunction

  assign adv = !m_tvalid || m_tready;
  assign pop = adv && !fifo_empty;

  always_comb begin
    for (int i = 0; i < 3; i++) a_wide[i] = RAW_BITS'($signed(rdata.a[i]));
  end

  // two normalisers in lock step
  obb_norm u_norm_a (.clk(clk), .en(adv), .vec_in(a_wide),  .q_out(nq), .zero_out(nz));
  obb_norm u_norm_t (.clk(clk), .en(adv), .vec_in(rdata.t), .q_out(mq), .zero_out(mz));

  // control travels beside the normalisers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NORM_LAT; k++) cd_valid[k] <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      c1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      cd_valid[0] <= pop;
      for (int k = 1; k < NORM_LAT; k++) cd_valid[k] <= cd_valid[k-1];
      p1_valid <= cd_valid[NORM_LAT-1];
      p2_valid <= p1_valid;
      c1_valid <= p2_valid;
      m_tvalid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cd_ctl[0] <= rdata.ctl;
      for (int k = 1; k < NORM_LAT; k++) cd_ctl[k] <= cd_ctl[k-1];
    end
  end

  // squared length of the x-axis cross
  assign sq1 = $signed(nq[1]) * $signed(nq[1]);
  assign sq2 = $signed(nq[2]) * $signed(nq[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_ctl <= cd_ctl[NORM_LAT-1];
      p1_n   <= nq;
      p1_m   <= mq;
      p1_s1  <= sq1[28:0];
      p1_s2  <= sq2[28:0];
      p1_deg <= !cd_ctl[NORM_LAT-1].ok || nz || (cd_ctl[NORM_LAT-1].pair && mz);
    end
  end

  // perpendicular axis, second operand and cross order
  always_comb begin
    if (EPS2_BITS'({1'b0, p1_s1} + {1'b0, p1_s2}) < eps2) begin
      perp[0] = OUT_BITS'(-$signed(p1_n[2]));
      perp[1] = '0;
      perp[2] = p1_n[0];
    end else begin
      perp[0] = '0;
      perp[1] = p1_n[2];
      perp[2] = OUT_BITS'(-$signed(p1_n[1]));
    end
    sec = p1_ctl.pair ? p1_m : perp;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_ctl <= p1_ctl;
      p2_deg <= p1_deg;
      p2_n   <= p1_n;
      p2_s   <= sec;
      p2_l   <= p1_ctl.swap ? sec : p1_n;
      p2_r   <= p1_ctl.swap ? p1_n : sec;
    end
  end

  // cross products
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_ctl  <= p2_ctl;
      c1_deg  <= p2_deg;
      c1_n    <= p2_n;
      c1_s    <= p2_s;
      c1_p[0] <= $signed(p2_l[1]) * $signed(p2_r[2]);
      c1_p[1] <= $signed(p2_l[2]) * $signed(p2_r[1]);
      c1_p[2] <= $signed(p2_l[2]) * $signed(p2_r[0]);
      c1_p[3] <= $signed(p2_l[0]) * $signed(p2_r[2]);
      c1_p[4] <= $signed(p2_l[0]) * $signed(p2_r[1]);
      c1_p[5] <= $signed(p2_l[1]) * $signed(p2_r[0]);
    end
  end

  // rounding and axis placement
  always_comb begin
    crs[0] = round_q(33'(c1_p[0]) - 33'(c1_p[1]));
    crs[1] = round_q(33'(c1_p[2]) - 33'(c1_p[3]));
    crs[2] = round_q(33'(c1_p[4]) - 33'(c1_p[5]));
    c_slot = 2'd3 - c1_ctl.n_slot - c1_ctl.s_slot;
    for (int k = 0; k < 3; k++) ax[k] = '0;
    if (!c1_deg) begin
      ax[c1_ctl.n_slot] = c1_n;
      ax[c1_ctl.s_slot] = c1_s;
      ax[c_slot]        = crs;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {ax[SLOT_W], ax[SLOT_V], ax[SLOT_U]};
      m_tuser <= c1_deg;
    end
  end

endmodule

// ----- hdl/orthonormal_basis_builder_core.sv -----
// Orthonormal basis builder: one Q2.14 basis u, v, w per word from one or two
// given vectors, selected by the operation code on s_tuser. The block takes one
// word per clock while its front-end queue is not full and delivers one result
// word per clock when the output is not stalled. An accepted word passes one
// product stage and one queue slot in the front end, then 57 normaliser stages
// dominated by the 32-step square root and the 15-step divider, then four
// stages for the perpendicular axis, the cross product and the output
// register. Invalid codes and zero-length vectors give zero axes with the
// degenerate flag on m_tuser. Register epsilon_length sits at byte address 0.
module orthonormal_basis_builder_core (
  input  logic                           clk,
  input  logic                           rst,
  // input handshake; the operation code (4 bits) rides on s_tuser
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // given_u_x, given_u_y, given_u_z, given_v_x, given_v_y, given_v_z,
  // given_w_x, given_w_y, given_w_z (16 bits each)
  input  logic [obb_pkg::DATA_BITS-1:0]  s_tdata,
  // operation
  input  logic [obb_pkg::OP_BITS-1:0]    s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // axis_u_x, axis_u_y, axis_u_z, axis_v_x, axis_v_y, axis_v_z,
  // axis_w_x, axis_w_y, axis_w_z (16 bits each)
  output logic [obb_pkg::DATA_BITS-1:0]  m_tdata,
  // degenerate
  output logic [0:0]                     m_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [obb_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import obb_pkg::*;

  logic [EPS_BITS-1:0]  eps;
  logic [EPS2_BITS-1:0] eps2;
  logic                 fifo_full, fifo_empty, push, pop;
  entry_t               push_data, rdata;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) eps <= EPS_RESET;
    else if (psel && penable && pwrite && pready && paddr == ADDR_EPS) eps <= pwdata[EPS_BITS-1:0];
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_EPS) prdata = 32'(eps);
  end

  // squared threshold
  always_ff @(posedge clk) begin
    eps2 <= eps * eps;
  end

  obb_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .fifo_full(fifo_full), .push(push), .push_data(push_data)
  );

  obb_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(push_data), .pop(pop), .rdata(rdata),
    .full(fifo_full), .empty(fifo_empty)
  );

  obb_back u_back (
    .clk(clk), .rst(rst), .eps2(eps2), .rdata(rdata), .fifo_empty(fifo_empty), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // degenerate words carry zero axes
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("degenerate word with non-zero axes");

  // the first component of axis u stays within one
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      ($signed(m_tdata[15:0]) <= 16'sd16384) && ($signed(m_tdata[15:0]) >= -16'sd16384))
    else $error("axis component out of range");

  // no result straight after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

// ----- tb/sv/tb_orthonormal_basis_builder_core.sv -----
// testbench for the orthonormal basis builder core: random and directed bases
`timescale 1ns / 100ps

module tb_orthonormal_basis_builder_core;
  import obb_pkg::*;

  localparam int LATENCY    = 62;
  localparam int WATCH_MAX  = 4000;
  localparam int RAND_ITEMS = 1500;
  localparam longint ONE_Q  = 64'sd1 << FRAC_BITS;

  typedef struct {
    logic [OP_BITS-1:0] op;
    logic [DATA_BITS-1:0] vecs;
  } basis_req_t;

  typedef struct {
    logic [DATA_BITS-1:0] axes;
    logic                 degen;
  } basis_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_BITS-1:0] s_tdata = '0;
  logic [OP_BITS-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DATA_BITS-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  orthonormal_basis_builder_core uut (.*);

  always #10 clk = ~clk;

  // predictor state
  longint unsigned eps_len = 164;
  basis_req_t pending_words[$];
  basis_res_t expected_bases[$];
  int mismatches = 0;
  int results_seen = 0;
  int watch = 0;
  bit stim_done = 0;
  bit quiet = 0;
  int src_idle = 0, sink_idle = 0;

  function automatic longint unsigned mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint sgn(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // prescale to at most 2^15 magnitude
  function automatic void fetch_vec(logic [DATA_BITS-1:0] d, int n, output longint v[3]);
    longint unsigned m = 0, mg[3];
    bit ng[3];
    int k = 0;
    for (int i = 0; i < 3; i++) begin
      longint x = longint'($signed(d[(3*n+i)*IN_BITS +: IN_BITS]));
      ng[i] = x < 0;
      mg[i] = mag(x);
      if (mg[i] > m) m = mg[i];
    end
    while ((m >> k) > (64'd1 << 15)) k++;
    for (int i = 0; i < 3; i++) v[i] = sgn(mg[i] >> k, ng[i]);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_vec(longint a[3], output longint q[3]);
    longint unsigned mg[3], m = 0, s = 0, len, r;
    for (int i = 0; i < 3; i++) begin
      mg[i] = mag(a[i]);
      if (mg[i] > m) m = mg[i];
      q[i] = 0;
    end
    if (m == 0) return 0;
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mg[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) s += mg[i] * mg[i];
    len = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      r = ((mg[i] << FRAC_BITS) + (len >> 1)) / len;
      if (r > ONE_Q) r = ONE_Q;
      q[i] = sgn(r, a[i] < 0);
    end
    return 1;
  endfunction

  function automatic longint round_sat(longint p);
    longint unsigned r = (mag(p) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (r > ONE_Q) r = ONE_Q;
    return sgn(r, p < 0);
  endfunction

  function automatic void cross_round(longint a[3], longint b[3], output longint d[3]);
    d[0] = round_sat(a[1]*b[2] - a[2]*b[1]);
    d[1] = round_sat(a[2]*b[0] - a[0]*b[2]);
    d[2] = round_sat(a[0]*b[1] - a[1]*b[0]);
  endfunction

  function automatic void cross_exact(longint a[3], longint b[3], output longint d[3]);
    d[0] = a[1]*b[2] - a[2]*b[1];
    d[1] = a[2]*b[0] - a[0]*b[2];
    d[2] = a[0]*b[1] - a[1]*b[0];
  endfunction

  // cross with x, falling back to y when too short
  function automatic void perp_of(longint a[3], output longint d[3]);
    longint xa[3], ya[3];
    longint unsigned l2;
    xa = '{ONE_Q, 0, 0};
    ya = '{0, ONE_Q, 0};
    cross_round(a, xa, d);
    l2 = mag(d[0])*mag(d[0]) + mag(d[1])*mag(d[1]) + mag(d[2])*mag(d[2]);
    if (l2 < eps_len * eps_len) cross_round(a, ya, d);
  endfunction

  function automatic basis_res_t build_basis(basis_req_t rq);
    longint gu[3], gv[3], gw[3], u[3], v[3], w[3], t[3];
    bit ok;
    basis_res_t res;
    fetch_vec(rq.vecs, 0, gu);
    fetch_vec(rq.vecs, 1, gv);
    fetch_vec(rq.vecs, 2, gw);
    u = '{0, 0, 0}; v = '{0, 0, 0}; w = '{0, 0, 0};
    case (rq.op)
      OP_FROM_U: begin
        ok = unit_vec(gu, u);
        if (ok) begin perp_of(u, v); cross_round(u, v, w); end
      end
      OP_FROM_V: begin
        ok = unit_vec(gv, v);
        if (ok) begin perp_of(v, u); cross_round(u, v, w); end
      end
      OP_FROM_W: begin
        ok = unit_vec(gw, w);
        if (ok) begin perp_of(w, u); cross_round(w, u, v); end
      end
      OP_UV: begin
        cross_exact(gu, gv, t);
        ok = unit_vec(gu, u) && unit_vec(t, w);
        if (ok) cross_round(w, u, v);
      end
      OP_UW: begin
        cross_exact(gw, gu, t);
        ok = unit_vec(gu, u) && unit_vec(t, v);
        if (ok) cross_round(u, v, w);
      end
      OP_VU: begin
        cross_exact(gu, gv, t);
        ok = unit_vec(gv, v) && unit_vec(t, w);
        if (ok) cross_round(v, w, u);
      end
      OP_VW: begin
        cross_exact(gv, gw, t);
        ok = unit_vec(gv, v) && unit_vec(t, u);
        if (ok) cross_round(u, v, w);
      end
      OP_WU: begin
        cross_exact(gw, gu, t);
        ok = unit_vec(gw, w) && unit_vec(t, v);
        if (ok) cross_round(v, w, u);
      end
      OP_WV: begin
        cross_exact(gv, gw, t);
        ok = unit_vec(gw, w) && unit_vec(t, u);
        if (ok) cross_round(w, u, v);
      end
      default: ok = 0;
    endcase
    if (!ok) begin
      u = '{0, 0, 0}; v = '{0, 0, 0}; w = '{0, 0, 0};
    end
    for (int i = 0; i < 3; i++) begin
      res.axes[i*16 +: 16]     = u[i][15:0];
      res.axes[(3+i)*16 +: 16] = v[i][15:0];
      res.axes[(6+i)*16 +: 16] = w[i][15:0];
    end
    res.degen = !ok;
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_bases.push_back(build_basis('{op: s_tuser, vecs: s_tdata}));
      end
      if (!s_tvalid || s_tready) begin
        if (src_idle > 0) begin
          src_idle <= src_idle - 1;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          basis_req_t rq;
          rq = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= rq.op;
          s_tdata  <= rq.vecs;
          if (!quiet && $urandom_range(0, 9) == 0) src_idle <= $urandom_range(1, 6);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and result stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        basis_res_t ex;
        results_seen++;
        if (expected_bases.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h deg %b", m_tdata, m_tuser);
        end else begin
          ex = expected_bases.pop_front();
          if (ex.axes !== m_tdata || ex.degen !== m_tuser[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h deg %b, got %h deg %b",
                       ex.axes, ex.degen, m_tdata, m_tuser);
          end
        end
      end
      if (sink_idle > 0) begin
        sink_idle <= sink_idle - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        sink_idle <= $urandom_range(0, 5);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WATCH_MAX) begin
      $display("[orthonormal_basis_builder_core] ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_word(logic [OP_BITS-1:0] op, logic [DATA_BITS-1:0] d);
    pending_words.push_back('{op: op, vecs: d});
  endtask

  task automatic queue_random(int n);
    logic [DATA_BITS-1:0] d;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 9; j++) d[j*16 +: 16] = rand_comp();
      // occasionally a vector along an axis, to exercise the y fallback
      if ($urandom_range(0, 7) == 0) begin
        d[$urandom_range(0, 2)*48 +: 48] = {16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                                            16'($urandom)};
      end
      queue_word($urandom_range(0, 9) == 0 ? OP_BITS'($urandom_range(9, 15))
                                           : OP_BITS'($urandom_range(0, 8)), d);
    end
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || s_tvalid || expected_bases.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_eps(logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_EPS; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    eps_len = val & 32'h7fff;
  endtask

  // stimulus
  initial begin
    logic [DATA_BITS-1:0] d;
    logic [31:0] evals [4];
    evals = '{32'd0, 32'h7fff, 32'd16384, 32'hffff_0001};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // directed words: every code, extremes, zero and axis-aligned vectors
    for (int op = 0; op < 16; op++) begin
      for (int j = 0; j < 9; j++) d[j*16 +: 16] = (op[0] ? 16'h8000 : 16'h7fff) + 16'(j);
      queue_word(OP_BITS'(op), d);
    end
    queue_word(OP_FROM_U, '0);
    queue_word(OP_UV, {96'd0, 16'd0, 16'd0, 16'd100});
    queue_word(OP_FROM_U, {96'd0, 16'd0, 16'd0, 16'h8000});
    queue_word(OP_FROM_V, {48'd0, 16'd0, 16'd0, 16'd5, 48'd0});
    queue_word(OP_FROM_W, {16'd0, 16'd0, 16'h7fff, 96'd0});
    queue_word(OP_VW, {16'd3, 16'd2, 16'd1, 16'd6, 16'd4, 16'd2, 48'd0});
    queue_word(OP_WV, {144{1'b1}});
    queue_random(200);
    // pause until the pipeline empties
    drain();
    foreach (evals[k]) begin
      write_eps(evals[k]);
      queue_random(250);
      drain();
    end
    write_eps(32'd164);
    quiet = 1;
    queue_random(300);
    drain();
    stim_done = 1;
    $display("covered all operation codes, zero and extreme vectors, %0d results, %0d eps settings",
             results_seen, 6);
    if (mismatches == 0) begin
      $display("[orthonormal_basis_builder_core] OK");
    end else begin
      $display("[orthonormal_basis_builder_core] ERROR");
    end
    $finish;
  end

endmodule
